// ----- rtl/core/arpc_pkg.sv -----
// Package for the ARP responder: field widths, protocol constants, result codes and
// the structs passed between the register file, the cache walker and the top level.
// No dependencies.
package arpc_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ    = 16'd1;
    localparam logic [15:0] ARP_OP_REP    = 16'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOT_ARP = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    localparam logic [1:0] TX_OP_NONE = 2'd0;
    localparam logic [1:0] TX_OP_REQ  = 2'd1;
    localparam logic [1:0] TX_OP_REP  = 2'd2;

    localparam logic [1:0] OUTCOME_NONE    = 2'd0;
    localparam logic [1:0] OUTCOME_PRESENT = 2'd1;
    localparam logic [1:0] OUTCOME_ADDED   = 2'd2;
    localparam logic [1:0] OUTCOME_FULL    = 2'd3;

    localparam logic       OP_RX_FRAME = 1'b0;
    localparam logic       OP_SEND_REQ = 1'b1;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_host_cfg;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_cache_req;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [1:0] outcome;
    } t_cache_rsp;

    typedef struct packed {
        logic [1:0]       status;
        logic             tx_valid;
        logic [1:0]       tx_arp_opcode;
        logic [MAC_W-1:0] tx_eth_dest;
        logic [IP_W-1:0]  tx_sender_ip;
        logic [MAC_W-1:0] tx_target_mac;
        logic [IP_W-1:0]  tx_tgt_ip;
        logic [1:0]       table_outcome;
    } t_result;

endpackage

// ----- rtl/core/arpc_if.sv -----
// Valid/ready channel interfaces for the ARP responder: request in, result out.
// No dependencies.
interface arpc_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] ether_type;
    logic [15:0] arp_opcode;
    logic [47:0] eth_source_mac;
    logic [47:0] sender_mac;
    logic [31:0] arp_sender_ip;
    logic [31:0] tgt_ip;

    modport source (
        output valid, opcode, ether_type, arp_opcode, eth_source_mac, sender_mac,
               arp_sender_ip, tgt_ip,
        input  ready
    );
    modport sink (
        input  valid, opcode, ether_type, arp_opcode, eth_source_mac, sender_mac,
               arp_sender_ip, tgt_ip,
        output ready
    );
endinterface

interface arpc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        tx_valid;
    logic [1:0]  tx_arp_opcode;
    logic [47:0] tx_eth_dest;
    logic [31:0] tx_sender_ip;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_tgt_ip;
    logic [1:0]  table_outcome;

    modport source (
        output valid, status, tx_valid, tx_arp_opcode, tx_eth_dest, tx_sender_ip,
               tx_target_mac, tx_tgt_ip, table_outcome,
        input  ready
    );
    modport sink (
        input  valid, status, tx_valid, tx_arp_opcode, tx_eth_dest, tx_sender_ip,
               tx_target_mac, tx_tgt_ip, table_outcome,
        output ready
    );
endinterface

// ----- rtl/core/arpc_regs.sv -----
// APB register file: host IP at byte address 0, host MAC at byte address 8.
// Depends on arpc_pkg.
module arpc_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [3:0]          i_paddr,
    input  logic [63:0]         i_pwdata,
    output logic [63:0]         o_prdata,
    output logic                o_pready,
    output arpc_pkg::t_host_cfg o_cfg
);
    import arpc_pkg::*;

    logic       w_wr;
    t_host_cfg  r_cfg;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            if (i_paddr[3]) begin
                r_cfg.mac <= i_pwdata[MAC_W-1:0];
            end else begin
                r_cfg.ip <= i_pwdata[IP_W-1:0];
            end
        end
    end

    always_comb begin
        if (i_paddr[3]) begin
            o_prdata = {{(64-MAC_W){1'b0}}, r_cfg.mac};
        end else begin
            o_prdata = {{(64-IP_W){1'b0}}, r_cfg.ip};
        end
    end
endmodule

// ----- rtl/core/arpc_cache.sv -----
// ARP cache: entry memory with per-entry valid bits and a sequential walker that finds
// the first matching or empty entry and installs the new IP/MAC pair. Depends on arpc_pkg.
module arpc_cache #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arpc_pkg::t_cache_req i_req,
    output arpc_pkg::t_cache_rsp o_rsp
);
    import arpc_pkg::*;

    localparam int K_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [K_W-1:0] K_LAST = K_W'(CACHE_ENTRIES - 1);

    typedef enum logic {
        C_IDLE,
        C_WALK
    } t_cstate;

    t_entry                   mem [CACHE_ENTRIES];
    t_entry                   r_rdata;
    logic [CACHE_ENTRIES-1:0] r_valid;
    t_cstate                  r_state;
    logic [K_W-1:0]           r_k;
    logic [K_W-1:0]           w_raddr;
    logic                     w_rd;
    logic [IP_W-1:0]          r_ip;
    logic [MAC_W-1:0]         r_mac;
    logic                     r_done;
    logic [1:0]               r_outcome;
    logic                     w_hit;
    logic                     w_empty;
    logic                     w_wr;

    assign w_hit   = r_valid[r_k] && (r_rdata.ip == r_ip);
    assign w_empty = !r_valid[r_k];
    assign w_wr    = (r_state == C_WALK) && w_empty && (r_ip != '0);
    assign w_rd    = i_req.start || (r_state == C_WALK);
    assign w_raddr = i_req.start ? '0 : r_k + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rdata <= mem[w_raddr];
        end
        if (w_wr) begin
            mem[r_k] <= '{ip: r_ip, mac: r_mac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= C_IDLE;
            r_valid   <= '0;
            r_done    <= 1'b0;
            r_k       <= '0;
            r_outcome <= OUTCOME_NONE;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_ip    <= i_req.ip;
                        r_mac   <= i_req.mac;
                        r_k     <= '0;
                        r_state <= C_WALK;
                    end
                end
                C_WALK: begin
                    if (w_hit) begin
                        r_outcome <= OUTCOME_PRESENT;
                        r_done    <= 1'b1;
                        r_state   <= C_IDLE;
                    end else if (w_empty) begin
                        // an empty entry also matches a learned IP of zero
                        r_outcome <= (r_ip == '0) ? OUTCOME_PRESENT : OUTCOME_ADDED;
                        if (w_wr) begin
                            r_valid[r_k] <= 1'b1;
                        end
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else if (r_k == K_LAST) begin
                        r_outcome <= OUTCOME_FULL;
                        r_done    <= 1'b1;
                        r_state   <= C_IDLE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_rsp.busy    = (r_state == C_WALK);
    assign o_rsp.done    = r_done;
    assign o_rsp.outcome = r_outcome;
endmodule

// ----- rtl/core/arp_responder_with_cache.sv -----
// ARP responder with a CACHE_ENTRIES-deep address cache. One request gives one result.
// Send requests, rejected, ignored and non-learning frames go from the result register
// through S_OUT into the output register; an ARP request or reply for this host first
// walks the cache one entry per cycle from index 0 in S_LEARN, stopping at the first
// matching or empty entry or at the last one, and its result then goes through S_OUT
// into the output register. A full output register that is not drained holds the result
// in S_OUT. The cache is empty right after reset, with no clearing pass. Requests are
// taken one at a time; the next is accepted while the previous result still waits in
// the output register. Host IP and MAC are written over APB at byte addresses 0 and 8;
// the user must write them only while idle, the block itself does not enforce it.
module arp_responder_with_cache #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    arpc_req_if.sink    i_req,
    arpc_res_if.source  o_res
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEARN,
        S_OUT
    } t_state;

    t_host_cfg  w_cfg;
    t_cache_req w_creq;
    t_cache_rsp w_crsp;
    t_state     r_state;
    t_result    r_res;
    t_result    n_res;
    t_result    r_out;
    logic       r_out_valid;
    logic       n_learn;
    logic       w_acc;
    logic       w_out_free;
    logic       w_out_load;

    arpc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    arpc_cache #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_cache (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .o_rsp   (w_crsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_out_load  = (r_state == S_OUT) && w_out_free;

    always_comb begin
        n_res   = '0;
        n_learn = 1'b0;
        if (i_req.opcode == OP_SEND_REQ) begin
            n_res.tx_valid      = 1'b1;
            n_res.tx_arp_opcode = TX_OP_REQ;
            n_res.tx_eth_dest   = MAC_BCAST;
            n_res.tx_sender_ip  = i_req.arp_sender_ip;
            n_res.tx_target_mac = MAC_BCAST;
            n_res.tx_tgt_ip     = i_req.tgt_ip;
        end else if (i_req.ether_type != ETHERTYPE_ARP) begin
            n_res.status = STATUS_NOT_ARP;
        end else if (i_req.tgt_ip != w_cfg.ip) begin
            n_res.status = STATUS_IGNORED;
        end else if (i_req.arp_opcode == ARP_OP_REQ) begin
            n_learn             = 1'b1;
            n_res.tx_valid      = 1'b1;
            n_res.tx_arp_opcode = TX_OP_REP;
            n_res.tx_eth_dest   = i_req.eth_source_mac;
            n_res.tx_sender_ip  = w_cfg.ip;
            n_res.tx_target_mac = i_req.sender_mac;
            n_res.tx_tgt_ip     = i_req.arp_sender_ip;
        end else if (i_req.arp_opcode == ARP_OP_REP) begin
            n_learn = 1'b1;
        end
    end

    assign w_creq.start = w_acc && n_learn;
    assign w_creq.ip    = i_req.arp_sender_ip;
    assign w_creq.mac   = i_req.sender_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_res   <= n_res;
                        r_state <= n_learn ? S_LEARN : S_OUT;
                    end
                end
                S_LEARN: begin
                    if (w_crsp.done) begin
                        r_res.table_outcome <= w_crsp.outcome;
                        r_state             <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.tx_valid      = r_out.tx_valid;
    assign o_res.tx_arp_opcode = r_out.tx_arp_opcode;
    assign o_res.tx_eth_dest   = r_out.tx_eth_dest;
    assign o_res.tx_sender_ip  = r_out.tx_sender_ip;
    assign o_res.tx_target_mac = r_out.tx_target_mac;
    assign o_res.tx_tgt_ip     = r_out.tx_tgt_ip;
    assign o_res.table_outcome = r_out.table_outcome;

    a_no_accept_while_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crsp.busy |-> !w_acc)
        else $error("request accepted during cache walk");

    a_done_only_when_learning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crsp.done |-> (r_state == S_LEARN))
        else $error("cache completion outside learn state");

    a_start_enters_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_creq.start |=> (r_state == S_LEARN) && w_crsp.busy)
        else $error("cache walk did not start");

    a_no_tx_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.tx_valid) |->
            (o_res.tx_arp_opcode == TX_OP_NONE) && (o_res.tx_tgt_ip == '0))
        else $error("frame fields set without outgoing frame");
endmodule

// ----- test/testbench.sv -----
// Testbench for arp_responder_with_cache: directed and random ARP traffic with a
// self-checking address-cache predictor and random stalls on both channels.
// Depends on arpc_pkg, arpc_req_if / arpc_res_if and the arp_responder_with_cache RTL.
module testbench;
    import arpc_pkg::*;

    localparam int CACHE_DEPTH = 16;
    localparam int DRAIN_CYCLES = CACHE_DEPTH + 8;
    localparam logic [3:0] REG_HOST_IP = 4'h0;
    localparam logic [3:0] REG_HW_ADDR = 4'h8;

    typedef struct packed {
        logic             opcode;
        logic [15:0]      ether_type;
        logic [15:0]      arp_opcode;
        logic [MAC_W-1:0] eth_source_mac;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  arp_sender_ip;
        logic [IP_W-1:0]  tgt_ip;
    } t_arp_item;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    arpc_req_if req_ch ();
    arpc_res_if res_ch ();

    arp_responder_with_cache #(.CACHE_ENTRIES(CACHE_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // predictor state
    logic [IP_W-1:0]  learned_ip  [CACHE_DEPTH];
    logic [MAC_W-1:0] learned_mac [CACHE_DEPTH];
    logic [IP_W-1:0]  host_ip  = '0;

    t_result pending_results[$];
    int      mismatch_count  = 0;
    int      results_checked = 0;
    int      status_seen[3]  = '{0, 0, 0};
    int      outcome_seen[4] = '{0, 0, 0, 0};
    int      replies_sent    = 0;
    int      requests_sent   = 0;
    bit      steady          = 1'b0;
    int      stall_left      = 0;

    always #4 i_clk = ~i_clk;

    initial begin
        #(8 * 400000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [1:0] learn_pair(input logic [IP_W-1:0] ip,
                                              input logic [MAC_W-1:0] mac);
        for (int k = 0; k < CACHE_DEPTH; k++) begin
            if (learned_ip[k] == ip)
                return OUTCOME_PRESENT;
            if (learned_ip[k] == '0) begin
                learned_ip[k]  = ip;
                learned_mac[k] = mac;
                return OUTCOME_ADDED;
            end
        end
        return OUTCOME_FULL;
    endfunction

    function automatic t_result predict_arp(input t_arp_item it);
        t_result r;
        r = '0;
        if (it.opcode == OP_SEND_REQ) begin
            r.tx_valid      = 1'b1;
            r.tx_arp_opcode = TX_OP_REQ;
            r.tx_eth_dest   = MAC_BCAST;
            r.tx_sender_ip  = it.arp_sender_ip;
            r.tx_target_mac = MAC_BCAST;
            r.tx_tgt_ip     = it.tgt_ip;
            requests_sent++;
        end else if (it.ether_type != ETHERTYPE_ARP) begin
            r.status = STATUS_NOT_ARP;
        end else if (it.tgt_ip != host_ip) begin
            r.status = STATUS_IGNORED;
        end else if (it.arp_opcode == ARP_OP_REQ) begin
            r.table_outcome = learn_pair(it.arp_sender_ip, it.sender_mac);
            r.tx_valid      = 1'b1;
            r.tx_arp_opcode = TX_OP_REP;
            r.tx_eth_dest   = it.eth_source_mac;
            r.tx_sender_ip  = host_ip;
            r.tx_target_mac = it.sender_mac;
            r.tx_tgt_ip     = it.arp_sender_ip;
            replies_sent++;
        end else if (it.arp_opcode == ARP_OP_REP) begin
            r.table_outcome = learn_pair(it.arp_sender_ip, it.sender_mac);
        end
        status_seen[r.status]++;
        outcome_seen[r.table_outcome]++;
        return r;
    endfunction

    function automatic t_arp_item make_frame(input logic [15:0] etype,
                                             input logic [15:0] aop,
                                             input logic [MAC_W-1:0] esrc,
                                             input logic [MAC_W-1:0] smac,
                                             input logic [IP_W-1:0] sip,
                                             input logic [IP_W-1:0] tip);
        t_arp_item it;
        it.opcode         = OP_RX_FRAME;
        it.ether_type     = etype;
        it.arp_opcode     = aop;
        it.eth_source_mac = esrc;
        it.sender_mac     = smac;
        it.arp_sender_ip  = sip;
        it.tgt_ip         = tip;
        return it;
    endfunction

    function automatic t_arp_item make_send(input logic [IP_W-1:0] sip,
                                            input logic [IP_W-1:0] tip);
        t_arp_item it;
        it = make_frame(16'hFFFF, 16'hFFFF, '1, '1, sip, tip);
        it.opcode = OP_SEND_REQ;
        return it;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [15:0] hi;
        hi = 16'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return {hi, $urandom};
        endcase
    endfunction

    function automatic t_arp_item random_item();
        t_arp_item it;
        int pick;
        it.opcode     = ($urandom_range(0, 99) < 15) ? OP_SEND_REQ : OP_RX_FRAME;
        it.ether_type = ($urandom_range(0, 99) < 85) ? ETHERTYPE_ARP
                                                     : 16'($urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.arp_opcode = ARP_OP_REQ;
        else if (pick < 85)
            it.arp_opcode = ARP_OP_REP;
        else
            it.arp_opcode = 16'($urandom_range(0, 16'hFFFF));
        it.eth_source_mac = random_mac();
        it.sender_mac     = random_mac();
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.arp_sender_ip = learned_ip[$urandom_range(0, CACHE_DEPTH - 1)];
        else if (pick < 60)
            it.arp_sender_ip = '0;
        else
            it.arp_sender_ip = $urandom;
        it.tgt_ip = ($urandom_range(0, 99) < 80) ? host_ip : $urandom;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("mismatch at result %0d: %s", results_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(res_ch.status), 64'(want.status));
                check_field("tx_valid", 64'(res_ch.tx_valid), 64'(want.tx_valid));
                check_field("tx_arp_opcode", 64'(res_ch.tx_arp_opcode),
                            64'(want.tx_arp_opcode));
                check_field("tx_eth_dest", 64'(res_ch.tx_eth_dest), 64'(want.tx_eth_dest));
                check_field("tx_sender_ip", 64'(res_ch.tx_sender_ip),
                            64'(want.tx_sender_ip));
                check_field("tx_target_mac", 64'(res_ch.tx_target_mac),
                            64'(want.tx_target_mac));
                check_field("tx_tgt_ip", 64'(res_ch.tx_tgt_ip), 64'(want.tx_tgt_ip));
                check_field("table_outcome", 64'(res_ch.table_outcome),
                            64'(want.table_outcome));
            end
            results_checked++;
        end
    end

    // result back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            res_ch.ready  <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 7) begin
            stall_left    <= $urandom_range(0, 2);
            res_ch.ready  <= 1'b0;
        end else begin
            res_ch.ready  <= 1'b1;
        end
    end

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_HOST_IP: host_ip = data[IP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_host(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        apb_write(REG_HOST_IP, {32'h0, ip});
        apb_write(REG_HW_ADDR, {16'h0, mac});
    endtask

    task automatic send_request(input t_arp_item it);
        if (!steady && $urandom_range(0, 99) < 14) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= it.opcode;
        req_ch.ether_type     <= it.ether_type;
        req_ch.arp_opcode     <= it.arp_opcode;
        req_ch.eth_source_mac <= it.eth_source_mac;
        req_ch.sender_mac     <= it.sender_mac;
        req_ch.arp_sender_ip  <= it.arp_sender_ip;
        req_ch.tgt_ip         <= it.tgt_ip;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_arp(it));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_frame_handling();
        logic [IP_W-1:0] hip;
        hip = 32'h0A00_0001;
        set_host(hip, 48'h0200_0000_0001);
        send_request(make_send('1, '0));
        send_request(make_send('0, '1));
        send_request(make_frame(16'h0800, ARP_OP_REQ, '1, '1, 32'h0A00_0002, hip));
        send_request(make_frame(16'hFFFF, ARP_OP_REQ, '1, '1, 32'h0A00_0002, hip));
        send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REQ, '1, '1, 32'h0A00_0002,
                                hip ^ 32'h1));
        send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REQ, '1, '0, 32'h0A00_0002, hip));
        send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REQ, '0, '1, 32'h0A00_0002, hip));
        send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REP, '1, '1, '1, hip));
        send_request(make_frame(ETHERTYPE_ARP, 16'h0000, '1, '1, 32'h0A00_0003, hip));
        send_request(make_frame(ETHERTYPE_ARP, 16'hFFFF, '1, '1, 32'h0A00_0003, hip));
        // sender IP zero hits the first empty entry
        send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REQ, 48'h1234_5678_9ABC,
                                48'hA5A5_5A5A_0F0F, '0, hip));
        wait_idle();
    endtask

    task automatic test_cache_fill();
        for (int n = 0; n < CACHE_DEPTH - 1; n++)
            send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REP, random_mac(), random_mac(),
                                    32'h0A00_0100 + n, host_ip));
        send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REQ, random_mac(), random_mac(),
                                '0, host_ip));
        send_request(make_frame(ETHERTYPE_ARP, ARP_OP_REQ, random_mac(), random_mac(),
                                learned_ip[CACHE_DEPTH - 1], host_ip));
        wait_idle();
    endtask

    task automatic run_random_phase(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                                    input int count, input bit no_gaps);
        t_arp_item it;
        set_host(ip, mac);
        steady = no_gaps;
        for (int n = 0; n < count; n++) begin
            it = random_item();
            send_request(it);
        end
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_random_mix();
        logic [15:0] hi;
        hi = 16'($urandom_range(0, 16'hFFFF));
        run_random_phase($urandom, {hi, $urandom}, 300, 1'b0);
        run_random_phase('0, '0, 200, 1'b1);
        run_random_phase('1, '1, 250, 1'b0);
        run_random_phase(learned_ip[$urandom_range(0, CACHE_DEPTH - 1)],
                         {hi ^ 16'h5A5A, $urandom}, 250, 1'b0);
    endtask

    initial begin
        for (int k = 0; k < CACHE_DEPTH; k++) begin
            learned_ip[k]  = '0;
            learned_mac[k] = '0;
        end
        req_ch.valid          <= 1'b0;
        req_ch.opcode         <= OP_RX_FRAME;
        req_ch.ether_type     <= '0;
        req_ch.arp_opcode     <= '0;
        req_ch.eth_source_mac <= '0;
        req_ch.sender_mac     <= '0;
        req_ch.arp_sender_ip  <= '0;
        req_ch.tgt_ip         <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_handling();
        test_cache_fill();
        test_random_mix();

        $display("checked %0d results: %0d replies, %0d broadcast requests,",
                 results_checked, replies_sent, requests_sent);
        $display("%0d non-ARP, %0d ignored; cache: %0d added, %0d present, %0d full",
                 status_seen[STATUS_NOT_ARP], status_seen[STATUS_IGNORED],
                 outcome_seen[OUTCOME_ADDED], outcome_seen[OUTCOME_PRESENT],
                 outcome_seen[OUTCOME_FULL]);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/arpc_pkg.sv
rtl/core/arpc_if.sv
rtl/core/arpc_regs.sv
rtl/core/arpc_cache.sv
rtl/core/arp_responder_with_cache.sv
test/testbench.sv
